### rtl/bounded_min_heap_top_k_unit_assert.svh
// assertion macros shared by the heap unit
`ifndef BOUNDED_MIN_HEAP_TOP_K_UNIT_ASSERT_SVH
`define BOUNDED_MIN_HEAP_TOP_K_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define BMHTK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define BMHTK_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define BMHTK_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define BMHTK_ASSERT(lbl, clk, rstn, prop, msg)
`define BMHTK_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BMHTK_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### rtl/bmhtk_pkg.sv
package bmhtk_pkg;

    localparam int DEPTH    = 64;
    localparam int CNT_W    = 7;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_REPLACED  = 3'd1,
        STAT_REJECTED  = 3'd2,
        STAT_EXTRACTED = 3'd3,
        STAT_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_ROOT,
        RD_LAST,
        RD_CHILDREN,
        RD_PARENT
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_MV,
        WR_IN,
        WR_CHILD,
        WR_PARENT
    } wr_sel_t;

    typedef enum logic [2:0] {
        POS_HOLD,
        POS_ONE,
        POS_CNT_PLUS1,
        POS_HALF,
        POS_CHILD
    } pos_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        RES_HOLD,
        RES_RD,
        RES_ZERO
    } res_op_t;

    typedef struct packed {
        logic    load_in;
        rd_sel_t rd;
        wr_sel_t wr;
        pos_op_t pos_op;
        cnt_op_t cnt_op;
        res_op_t res_op;
        logic    status_load;
        status_t status;
        logic    mv_load;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_insert;
        logic below_cap;
        logic cnt_zero;
        logic rejected;
        logic has_child;
        logic sd_stop;
        logic at_root;
        logic su_move;
        logic out_free;
    } dp_stat_t;

endpackage

### rtl/bmhtk_ctrl.sv
`include "bounded_min_heap_top_k_unit_assert.svh"

module bmhtk_ctrl import bmhtk_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_CHECK   = 10'b0000000010,
        S_RM_LOAD = 10'b0000000100,
        S_SD_RD   = 10'b0000001000,
        S_SD_CMP  = 10'b0000010000,
        S_SU_RD   = 10'b0000100000,
        S_SU_CMP  = 10'b0001000000,
        S_FIN_RD  = 10'b0010000000,
        S_FIN_CAP = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        cmd.load_in     = 1'b0;
        cmd.rd          = RD_NONE;
        cmd.wr          = WR_NONE;
        cmd.pos_op      = POS_HOLD;
        cmd.cnt_op      = CNT_HOLD;
        cmd.res_op      = RES_HOLD;
        cmd.status_load = 1'b0;
        cmd.status      = STAT_INSERTED;
        cmd.mv_load     = 1'b0;
        cmd.load_out    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    cmd.rd      = RD_ROOT;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.status_load = 1'b1;
                if (stat.is_insert) begin
                    if (stat.below_cap) begin
                        cmd.status = STAT_INSERTED;
                        cmd.pos_op = POS_CNT_PLUS1;
                        state_next = S_SU_RD;
                    end else if (stat.rejected) begin
                        cmd.status = STAT_REJECTED;
                        cmd.res_op = RES_RD;
                        state_next = S_DONE;
                    end else begin
                        cmd.status = STAT_REPLACED;
                        cmd.rd     = RD_LAST;
                        state_next = S_RM_LOAD;
                    end
                end else begin
                    if (stat.cnt_zero) begin
                        cmd.status = STAT_EMPTY;
                        cmd.res_op = RES_ZERO;
                        state_next = S_DONE;
                    end else begin
                        cmd.status = STAT_EXTRACTED;
                        cmd.res_op = RES_RD;
                        cmd.rd     = RD_LAST;
                        state_next = S_RM_LOAD;
                    end
                end
            end
            S_RM_LOAD: begin
                cmd.mv_load = 1'b1;
                cmd.cnt_op  = CNT_DEC;
                cmd.pos_op  = POS_ONE;
                state_next  = S_SD_RD;
            end
            S_SD_RD: begin
                if (stat.has_child) begin
                    cmd.rd     = RD_CHILDREN;
                    state_next = S_SD_CMP;
                end else begin
                    cmd.wr = WR_MV;
                    if (stat.is_insert) begin
                        cmd.pos_op = POS_CNT_PLUS1;
                        state_next = S_SU_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SD_CMP: begin
                if (stat.sd_stop) begin
                    cmd.wr = WR_MV;
                    if (stat.is_insert) begin
                        cmd.pos_op = POS_CNT_PLUS1;
                        state_next = S_SU_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    cmd.wr     = WR_CHILD;
                    cmd.pos_op = POS_CHILD;
                    state_next = S_SD_RD;
                end
            end
            S_SU_RD: begin
                if (stat.at_root) begin
                    cmd.wr     = WR_IN;
                    cmd.cnt_op = CNT_INC;
                    state_next = S_FIN_RD;
                end else begin
                    cmd.rd     = RD_PARENT;
                    state_next = S_SU_CMP;
                end
            end
            S_SU_CMP: begin
                if (stat.su_move) begin
                    cmd.wr     = WR_PARENT;
                    cmd.pos_op = POS_HALF;
                    state_next = S_SU_RD;
                end else begin
                    cmd.wr     = WR_IN;
                    cmd.cnt_op = CNT_INC;
                    state_next = S_FIN_RD;
                end
            end
            S_FIN_RD: begin
                cmd.rd     = RD_ROOT;
                state_next = S_FIN_CAP;
            end
            S_FIN_CAP: begin
                cmd.res_op = RES_RD;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // one request in flight at a time
    `BMHTK_ASSERT_NXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready, "second request taken while busy")
    `BMHTK_ASSERT_NXT(a_back_idle, aclk, aresetn, cmd.load_out, s_ready, "no return to idle after result")
    `BMHTK_ASSERT_IMP(a_inc_with_new, aclk, aresetn, cmd.cnt_op == CNT_INC, cmd.wr == WR_IN, "count grew without placing new item")

endmodule

### rtl/bmhtk_dp.sv
`include "bounded_min_heap_top_k_unit_assert.svh"

module bmhtk_dp import bmhtk_pkg::*; #(
    parameter int KEY_WIDTH = 32,
    parameter int ID_WIDTH  = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CNT_W-1:0]     cfg_wdata,
    input  logic                 s_mode,
    input  logic [KEY_WIDTH-1:0] s_item_key,
    input  logic [ID_WIDTH-1:0]  s_item_id,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [KEY_WIDTH-1:0] m_out_key,
    output logic [ID_WIDTH-1:0]  m_out_id,
    output logic [CNT_W-1:0]     m_fill_count,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int EW = KEY_WIDTH + ID_WIDTH;

    function automatic logic [AW-1:0] to_idx(input logic [POS_W-1:0] p);
        return AW'(p - POS_W'(1));
    endfunction

    logic [EW-1:0] heap_mem [DEPTH];

    logic [CNT_W-1:0]     capacity_reg, capacity_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 in_mode_reg, in_mode_next;
    logic [KEY_WIDTH-1:0] in_key_reg, in_key_next;
    logic [ID_WIDTH-1:0]  in_id_reg, in_id_next;
    logic [KEY_WIDTH-1:0] mv_key_reg, mv_key_next;
    logic [ID_WIDTH-1:0]  mv_id_reg, mv_id_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    status_t              res_status_reg, res_status_next;
    logic [KEY_WIDTH-1:0] res_key_reg, res_key_next;
    logic [ID_WIDTH-1:0]  res_id_reg, res_id_next;
    status_t              m_status_reg, m_status_next;
    logic [KEY_WIDTH-1:0] m_key_reg, m_key_next;
    logic [ID_WIDTH-1:0]  m_id_reg, m_id_next;
    logic [CNT_W-1:0]     m_fill_reg, m_fill_next;
    logic [EW-1:0]        rda_reg, rdb_reg;

    logic [CNT_W-1:0]     cap_eff;
    logic [POS_W-1:0]     cnt_ext;
    logic [POS_W-1:0]     child_pos, child1_pos, parent_pos, rda_pos, sel_pos;
    logic                 c1_ok, b_smaller;
    logic [KEY_WIDTH-1:0] rda_key, rdb_key, sel_key;
    logic [ID_WIDTH-1:0]  rda_id;
    logic [EW-1:0]        sel_entry;
    logic                 rd_en, rdb_en, wr_en;
    logic [AW-1:0]        addr_a, addr_b, wr_addr;
    logic [EW-1:0]        wr_data;

    // effective capacity, zero reads as one and saturates at the store depth
    always_comb begin
        if (capacity_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (int'(capacity_reg) > DEPTH) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = capacity_reg;
        end
    end

    assign cnt_ext    = POS_W'(cnt_reg);
    assign child_pos  = {pos_reg[POS_W-2:0], 1'b0};
    assign child1_pos = {pos_reg[POS_W-2:0], 1'b1};
    assign parent_pos = pos_reg >> 1;
    assign c1_ok      = (child1_pos <= cnt_ext);

    assign rda_key = rda_reg[EW-1:ID_WIDTH];
    assign rda_id  = rda_reg[ID_WIDTH-1:0];
    assign rdb_key = rdb_reg[EW-1:ID_WIDTH];

    // pick the smaller child, left on a tie
    assign b_smaller = c1_ok && (rda_key > rdb_key);
    assign sel_entry = b_smaller ? rdb_reg : rda_reg;
    assign sel_pos   = b_smaller ? child1_pos : child_pos;
    assign sel_key   = sel_entry[EW-1:ID_WIDTH];

    always_comb begin
        case (cmd.rd)
            RD_ROOT:     rda_pos = POS_W'(1);
            RD_LAST:     rda_pos = cnt_ext;
            RD_CHILDREN: rda_pos = child_pos;
            RD_PARENT:   rda_pos = parent_pos;
            default:     rda_pos = POS_W'(1);
        endcase
    end

    assign rd_en   = (cmd.rd != RD_NONE);
    assign rdb_en  = (cmd.rd == RD_CHILDREN);
    assign addr_a  = to_idx(rda_pos);
    assign addr_b  = c1_ok ? to_idx(child1_pos) : to_idx(child_pos);
    assign wr_en   = (cmd.wr != WR_NONE);
    assign wr_addr = to_idx(pos_reg);

    always_comb begin
        case (cmd.wr)
            WR_MV:     wr_data = {mv_key_reg, mv_id_reg};
            WR_IN:     wr_data = {in_key_reg, in_id_reg};
            WR_CHILD:  wr_data = sel_entry;
            WR_PARENT: wr_data = rda_reg;
            default:   wr_data = rda_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rda_reg <= heap_mem[addr_a];
        end
        if (rdb_en) begin
            rdb_reg <= heap_mem[addr_b];
        end
    end

    always_comb begin
        capacity_next   = cfg_we ? cfg_wdata : capacity_reg;
        in_mode_next    = in_mode_reg;
        in_key_next     = in_key_reg;
        in_id_next      = in_id_reg;
        mv_key_next     = mv_key_reg;
        mv_id_next      = mv_id_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_id_next     = res_id_reg;
        m_status_next   = m_status_reg;
        m_key_next      = m_key_reg;
        m_id_next       = m_id_reg;
        m_fill_next     = m_fill_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        if (cmd.load_in) begin
            in_mode_next = s_mode;
            in_key_next  = s_item_key;
            in_id_next   = s_item_id;
        end
        if (cmd.mv_load) begin
            mv_key_next = rda_key;
            mv_id_next  = rda_id;
        end
        if (cmd.status_load) begin
            res_status_next = cmd.status;
        end

        case (cmd.res_op)
            RES_RD: begin
                res_key_next = rda_key;
                res_id_next  = rda_id;
            end
            RES_ZERO: begin
                res_key_next = '0;
                res_id_next  = '0;
            end
            default: begin
                res_key_next = res_key_reg;
            end
        endcase

        case (cmd.pos_op)
            POS_ONE:       pos_next = POS_W'(1);
            POS_CNT_PLUS1: pos_next = cnt_ext + POS_W'(1);
            POS_HALF:      pos_next = parent_pos;
            POS_CHILD:     pos_next = sel_pos;
            default:       pos_next = pos_reg;
        endcase

        case (cmd.cnt_op)
            CNT_INC: cnt_next = cnt_reg + CNT_W'(1);
            CNT_DEC: cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase

        if (cmd.load_out) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_key_next    = res_key_reg;
            m_id_next     = res_id_reg;
            m_fill_next   = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            capacity_reg <= capacity_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_mode_reg    <= in_mode_next;
        in_key_reg     <= in_key_next;
        in_id_reg      <= in_id_next;
        mv_key_reg     <= mv_key_next;
        mv_id_reg      <= mv_id_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_id_reg     <= res_id_next;
        m_status_reg   <= m_status_next;
        m_key_reg      <= m_key_next;
        m_id_reg       <= m_id_next;
        m_fill_reg     <= m_fill_next;
    end

    assign stat.is_insert = !in_mode_reg;
    assign stat.below_cap = (cnt_reg < cap_eff);
    assign stat.cnt_zero  = (cnt_reg == '0);
    assign stat.rejected  = (in_key_reg <= rda_key);
    assign stat.has_child = (child_pos <= cnt_ext);
    assign stat.sd_stop   = (mv_key_reg <= sel_key);
    assign stat.at_root   = (pos_reg == POS_W'(1));
    assign stat.su_move   = (rda_key > in_key_reg);
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_out_key    = m_key_reg;
    assign m_out_id     = m_id_reg;
    assign m_fill_count = m_fill_reg;

    `BMHTK_ASSERT(a_cnt_bound, aclk, aresetn, int'(cnt_reg) <= DEPTH, "fill count above depth")
    `BMHTK_ASSERT_IMP(a_load_free, aclk, aresetn, cmd.load_out, !m_valid_reg || m_ready, "result overwrote a pending one")
    `BMHTK_ASSERT_IMP(a_cnt_step, aclk, aresetn, cnt_reg != $past(cnt_reg), (cnt_reg == $past(cnt_reg) + 1'b1) || (cnt_reg == $past(cnt_reg) - 1'b1), "fill count jumped")

endmodule

### rtl/bounded_min_heap_top_k_unit.sv
// Top-K selector built on a binary min-heap of key and id pairs held in a
// single-write, dual-read memory of DEPTH entries. An insert adds the item
// while the heap is below capacity, replaces the minimum when the heap is full
// and the key is strictly greater, and is rejected otherwise; an extract
// removes and returns the minimum. One request is worked on at a time: accept
// and root read come first, then each heap level walked is a registered memory
// read followed by a compare and write. A plain insert walks up, an extract
// walks down, and a replace walks down and then up, each walk moving up to
// log2 of the fill in levels; a reject or an extract on an empty heap walks
// no levels. The result sits in an output register, so a new request is
// accepted while the previous result waits; a result still waiting when the
// next one is ready holds the unit. Capacity is to be written only while idle
// by the user; the block does not enforce it. Zero acts as one and values
// above DEPTH saturate. Heap memory has no reset and needs no clearing pass.
module bounded_min_heap_top_k_unit import bmhtk_pkg::*; #(
    parameter int KEY_WIDTH = 32,
    parameter int ID_WIDTH  = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CNT_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [KEY_WIDTH-1:0] s_item_key,
    input  logic [ID_WIDTH-1:0]  s_item_id,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [KEY_WIDTH-1:0] m_out_key,
    output logic [ID_WIDTH-1:0]  m_out_id,
    output logic [CNT_W-1:0]     m_fill_count
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bmhtk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bmhtk_dp #(
        .KEY_WIDTH (KEY_WIDTH),
        .ID_WIDTH  (ID_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_mode       (s_mode),
        .s_item_key   (s_item_key),
        .s_item_id    (s_item_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_out_key    (m_out_key),
        .m_out_id     (m_out_id),
        .m_fill_count (m_fill_count),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bmhtk_pkg::*;

    localparam int KW          = 32;
    localparam int IW          = 32;
    localparam int HEAP_DEPTH  = DEPTH;
    localparam int STALL_LIMIT = 4000;
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef struct packed {
        status_t          status;
        logic [KW-1:0]    key;
        logic [IW-1:0]    id;
        logic [CNT_W-1:0] fill;
    } heap_result_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CNT_W-1:0]    cfg_wdata = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic                s_mode    = OP_INSERT;
    logic [KW-1:0]       s_item_key = '0;
    logic [IW-1:0]       s_item_id  = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [KW-1:0]       m_out_key;
    logic [IW-1:0]       m_out_id;
    logic [CNT_W-1:0]    m_fill_count;

    // predicted heap contents, kept 1-based like the hardware
    logic [KW-1:0]    heap_keys [1:HEAP_DEPTH];
    logic [IW-1:0]    heap_ids  [1:HEAP_DEPTH];
    int               heap_fill = 0;
    logic [CNT_W-1:0] capacity_reg = CAP_RESET;

    heap_result_t pending_results [$];
    int           mismatch_count = 0;
    int           stall_count    = 0;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;
    int           hold_cycles    = 0;

    bounded_min_heap_top_k_unit #(
        .KEY_WIDTH(KW),
        .ID_WIDTH(IW)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_mode(s_mode),
        .s_item_key(s_item_key),
        .s_item_id(s_item_id),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_out_key(m_out_key),
        .m_out_id(m_out_id),
        .m_fill_count(m_fill_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void heap_push(input logic [KW-1:0] k, input logic [IW-1:0] t);
        int pos;
        pos = heap_fill + 1;
        while (pos > 1 && heap_keys[pos / 2] > k) begin
            heap_keys[pos] = heap_keys[pos / 2];
            heap_ids[pos]  = heap_ids[pos / 2];
            pos = pos / 2;
        end
        heap_keys[pos] = k;
        heap_ids[pos]  = t;
        heap_fill++;
    endfunction

    function automatic void heap_pop_min();
        int            pos;
        int            c;
        logic [KW-1:0] tk;
        logic [IW-1:0] tt;
        heap_keys[1] = heap_keys[heap_fill];
        heap_ids[1]  = heap_ids[heap_fill];
        heap_fill--;
        pos = 1;
        while (2 * pos <= heap_fill) begin
            c = 2 * pos;
            if (c + 1 <= heap_fill && heap_keys[c] > heap_keys[c + 1])
                c = c + 1;
            if (heap_keys[pos] <= heap_keys[c])
                break;
            tk = heap_keys[pos];
            tt = heap_ids[pos];
            heap_keys[pos] = heap_keys[c];
            heap_ids[pos]  = heap_ids[c];
            heap_keys[c] = tk;
            heap_ids[c]  = tt;
            pos = c;
        end
    endfunction

    function automatic heap_result_t heap_predict(input logic op, input logic [KW-1:0] k,
                                                  input logic [IW-1:0] t);
        heap_result_t r;
        int           lim;
        lim = (capacity_reg == 0) ? 1 : ((capacity_reg > HEAP_DEPTH) ? HEAP_DEPTH : capacity_reg);
        r.key = '0;
        r.id  = '0;
        if (op == OP_INSERT) begin
            if (heap_fill >= lim) begin
                if (k <= heap_keys[1]) begin
                    r.status = STAT_REJECTED;
                end else begin
                    heap_pop_min();
                    heap_push(k, t);
                    r.status = STAT_REPLACED;
                end
            end else begin
                heap_push(k, t);
                r.status = STAT_INSERTED;
            end
            r.key = heap_keys[1];
            r.id  = heap_ids[1];
        end else if (heap_fill == 0) begin
            r.status = STAT_EMPTY;
        end else begin
            r.key = heap_keys[1];
            r.id  = heap_ids[1];
            heap_pop_min();
            r.status = STAT_EXTRACTED;
        end
        r.fill = heap_fill[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // predict on each accepted request, then check each accepted result
    always @(posedge aclk) begin
        heap_result_t exp_r;
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_results.push_back(heap_predict(s_mode, s_item_key, s_item_id));
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result status %0d key %0h id %0h fill %0d",
                             $time, m_status, m_out_key, m_out_id, m_fill_count);
                    mismatch_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    report_field("status", 64'(exp_r.status), 64'(m_status));
                    report_field("out_key", 64'(exp_r.key), 64'(m_out_key));
                    report_field("out_id", 64'(exp_r.id), 64'(m_out_id));
                    report_field("fill_count", 64'(exp_r.fill), 64'(m_fill_count));
                end
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send_request(input logic op, input logic [KW-1:0] k,
                                input logic [IW-1:0] t);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= op;
        s_item_key <= k;
        s_item_id  <= t;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_capacity(input logic [CNT_W-1:0] v);
        wait_drained();
        cfg_we       <= 1'b1;
        cfg_wdata    <= v;
        capacity_reg = v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [KW-1:0] rand_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom();
            5, 6, 7:       return $urandom_range(0, 15);
            8:             return $urandom_range(0, 1) ? '1 : '0;
            default:       return 32'hFFFF_FFF0 + $urandom_range(0, 15);
        endcase
    endfunction

    // bursts of fill, churn and drain so the heap reaches capacity and empties again
    task automatic run_segment(input int n);
        int left;
        int burst;
        int ins_pct;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(5, 40);
            if (burst > left)
                burst = left;
            case ($urandom_range(0, 3))
                0, 1:    ins_pct = 90;
                2:       ins_pct = 65;
                default: ins_pct = 15;
            endcase
            repeat (burst)
                send_request(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_EXTRACT,
                             rand_key(), $urandom());
            left -= burst;
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        // empty heap, key and id extremes
        send_request(OP_EXTRACT, '1, '1);
        send_request(OP_INSERT, '0, '0);
        send_request(OP_INSERT, '1, '1);
        send_request(OP_INSERT, 32'd5, 32'h1234);
        send_request(OP_EXTRACT, '0, '0);
        send_request(OP_EXTRACT, '0, '0);
        send_request(OP_EXTRACT, '0, '0);
        send_request(OP_EXTRACT, '0, '0);
        // capacity one, equal key when full
        set_capacity(7'd1);
        send_request(OP_INSERT, 32'd10, 32'hA);
        send_request(OP_INSERT, 32'd10, 32'hB);
        send_request(OP_INSERT, 32'd9, 32'hC);
        send_request(OP_INSERT, 32'd11, 32'hD);
        send_request(OP_EXTRACT, '0, '0);
        // capacity zero acts as one
        set_capacity(7'd0);
        send_request(OP_INSERT, 32'd3, 32'h1);
        send_request(OP_INSERT, 32'd3, 32'h2);
        send_request(OP_INSERT, 32'd4, 32'h3);
        // saturated capacity, then lowered below the fill
        set_capacity(7'd127);
        send_request(OP_INSERT, 32'd7, 32'h4);
        send_request(OP_INSERT, 32'd2, 32'h5);
        set_capacity(7'd2);
        send_request(OP_INSERT, 32'd1, 32'h6);
        send_request(OP_INSERT, 32'd100, 32'h7);
        send_request(OP_EXTRACT, '0, '0);
        send_request(OP_EXTRACT, '0, '0);
        send_request(OP_EXTRACT, '0, '0);
        send_request(OP_EXTRACT, '0, '0);
    endtask

    task automatic test_random_slow_receiver();
        send_idle_pct = 7;
        recv_idle_pct = 49;
        set_capacity(7'd64);
        run_segment(200);
        set_capacity(7'd1);
        run_segment(50);
        set_capacity(7'd127);
        run_segment(60);
    endtask

    task automatic test_random_slow_sender();
        send_idle_pct = 49;
        recv_idle_pct = 7;
        set_capacity(7'd0);
        run_segment(40);
        set_capacity(CNT_W'($urandom_range(2, 8)));
        run_segment(100);
        set_capacity(7'd5);
        run_segment(100);
    endtask

    task automatic test_random_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_capacity(CNT_W'($urandom_range(1, 127)));
        run_segment(100);
        set_capacity(7'd16);
        run_segment(100);
        set_capacity(7'd64);
        run_segment(150);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_capacity(7'd8);
        @(posedge aclk);
        hold_cycles = 300;
        @(negedge aclk);
        run_segment(30);
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random_slow_receiver();
        test_random_slow_sender();
        test_random_full_rate();
        test_backpressure();
        wait_drained();
        repeat (50) @(negedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/bmhtk_pkg.sv
rtl/bmhtk_ctrl.sv
rtl/bmhtk_dp.sv
rtl/bounded_min_heap_top_k_unit.sv
test/tb_top.sv
